>>> rtl/pstp_pkg.sv
// ----------------------------------------------------------------------------
// pstp_pkg
// Shared types, constants and lookup tables of the PCM to PDM block encoder.
// ----------------------------------------------------------------------------
package pstp_pkg;

  localparam int unsigned VOL_W     = 7;
  localparam int unsigned VOL_MAX   = 100;
  localparam int unsigned VOL_RESET = 70;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORDS     = 8;
  localparam int unsigned WCNT_W    = $clog2(WORDS);
  localparam int unsigned DIDX_W    = 6;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [LEVEL_W-1:0] MID_LEVEL = 8'd128;
  localparam logic [6:0]         MAX_SWING = 7'd127;
  localparam logic [WCNT_W-1:0]  LAST_IDX  = WCNT_W'(WORDS - 1);

  typedef logic [GAIN_W-1:0] gain_lut_t [2**VOL_W];

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } pstp_q_stat_t;

  // gain per volume code, interpolated from the log-law steps at elaboration
  function automatic gain_lut_t build_gain_lut();
    int steps [12];
    gain_lut_t lut;
    int v;
    int lo;
    int hi;
    steps = '{0, 8, 24, 40, 56, 80, 104, 128, 162, 196, 255, 255};
    for (int i = 0; i < 2**VOL_W; i++) begin
      v = (i > VOL_MAX) ? VOL_MAX : i;
      lo = steps[v / 10];
      hi = steps[v / 10 + 1];
      lut[i] = GAIN_W'(lo + ((hi - lo) * (v % 10)) / 10);
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

  // dither mask per low three level bits
  function automatic logic [7:0] dither_mask(input logic [2:0] sel);
    logic [7:0] m;
    case (sel)
      3'd0:    m = 8'h00;
      3'd1:    m = 8'h10;
      3'd2:    m = 8'h22;
      3'd3:    m = 8'h4a;
      3'd4:    m = 8'h55;
      3'd5:    m = 8'h6d;
      3'd6:    m = 8'h77;
      3'd7:    m = 8'h7f;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // evenly spaced bit patterns, index is the number of set bits
  function automatic logic [WORD_W-1:0] density_word(input logic [DIDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      6'd0:    w = 32'h00000000;
      6'd1:    w = 32'h80000000;
      6'd2:    w = 32'h80008000;
      6'd3:    w = 32'h80200400;
      6'd4:    w = 32'h80808080;
      6'd5:    w = 32'h82081040;
      6'd6:    w = 32'h84208420;
      6'd7:    w = 32'h88442210;
      6'd8:    w = 32'h88888888;
      6'd9:    w = 32'h91224488;
      6'd10:   w = 32'h92489248;
      6'd11:   w = 32'ha4924924;
      6'd12:   w = 32'ha4a4a4a4;
      6'd13:   w = 32'ha94a5294;
      6'd14:   w = 32'haa54aa54;
      6'd15:   w = 32'haaaa5554;
      6'd16:   w = 32'haaaaaaaa;
      6'd17:   w = 32'hd555aaaa;
      6'd18:   w = 32'hd5aad5aa;
      6'd19:   w = 32'hd6b5ad6a;
      6'd20:   w = 32'hdadadada;
      6'd21:   w = 32'hdb6db6da;
      6'd22:   w = 32'hedb6edb6;
      6'd23:   w = 32'heeddbb76;
      6'd24:   w = 32'heeeeeeee;
      6'd25:   w = 32'hf7bbddee;
      6'd26:   w = 32'hfbdefbde;
      6'd27:   w = 32'hfdf7efbe;
      6'd28:   w = 32'hfefefefe;
      6'd29:   w = 32'hffdffbfe;
      6'd30:   w = 32'hfffefffe;
      6'd31:   w = 32'hfffffffe;
      6'd32:   w = 32'hffffffff;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pstp_front.sv
// ----------------------------------------------------------------------------
// pstp_front
// Holds the volume register, accepts samples and turns each into a level.
// ----------------------------------------------------------------------------
module pstp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pstp_pkg::SAMPLE_W-1:0]   in_pcm_sample,
  input  logic                            in_silent,
  input  logic                            cfg_we,
  input  logic [pstp_pkg::VOL_W-1:0]      cfg_wdata,
  input  pstp_pkg::pstp_q_stat_t          q_stat,
  output logic                            push,
  output logic [pstp_pkg::LEVEL_W-1:0]    push_level
);
  import pstp_pkg::*;

  logic [VOL_W-1:0]          volume_r;
  logic [GAIN_W-1:0]         gain;
  logic                      pos;
  logic [SAMPLE_W-1:0]       mag;
  logic [SAMPLE_W+GAIN_W-1:0] prod;
  logic [LEVEL_W-1:0]        swing;
  logic [LEVEL_W-1:0]        level;

  // volume register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOL_W'(VOL_RESET);
    end else if (cfg_we) begin
      volume_r <= cfg_wdata;
    end
  end

  // gain lookup and offset scaling
  always_comb begin
    gain  = GAIN_LUT[volume_r];
    pos   = in_pcm_sample[SAMPLE_W-1];
    mag   = pos ? (in_pcm_sample - MID_LEVEL) : (MID_LEVEL - in_pcm_sample);
    prod  = SAMPLE_W'(mag) * GAIN_W'(gain);
    swing = prod[SAMPLE_W+GAIN_W-2:7];
    if (in_silent) begin
      level = MID_LEVEL;
    end else if (pos) begin
      level = (swing > {1'b0, MAX_SWING}) ? 8'd255 : (MID_LEVEL + swing);
    end else begin
      level = (swing > {1'b0, MAX_SWING}) ? 8'd0 : (MID_LEVEL - swing);
    end
  end

  // request goes straight into the queue
  assign in_ready   = !q_stat.full;
  assign push       = in_valid && !q_stat.full;
  assign push_level = level;

endmodule

>>> rtl/pstp_queue.sv
// ----------------------------------------------------------------------------
// pstp_queue
// Short level queue between the front and back parts.
// ----------------------------------------------------------------------------
module pstp_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [pstp_pkg::LEVEL_W-1:0]  push_level,
  input  logic                          pop,
  output logic [pstp_pkg::LEVEL_W-1:0]  head_level,
  output pstp_pkg::pstp_q_stat_t        q_stat
);
  import pstp_pkg::*;

  logic [LEVEL_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_level;
    end
  end

  // pointers and fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head_level   = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

>>> rtl/pstp_back.sv
// ----------------------------------------------------------------------------
// pstp_back
// Expands each queued level into eight dithered pulse-density words.
// ----------------------------------------------------------------------------
module pstp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pstp_pkg::pstp_q_stat_t        q_stat,
  input  logic [pstp_pkg::LEVEL_W-1:0]  head_level,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pstp_pkg::WORD_W-1:0]   out_pdm_word,
  output logic                          out_last_word
);
  import pstp_pkg::*;

  logic                  busy_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [WCNT_W-1:0]     wcnt_r;
  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_word_r;
  logic                  out_last_r;
  logic                  load_ok;
  logic                  emit;
  logic                  done;
  logic [7:0]            msk;
  logic                  extra;
  logic [DIDX_W-1:0]     didx;

  // word for the current position
  always_comb begin
    msk   = dither_mask(level_r[2:0]);
    extra = (wcnt_r != LAST_IDX) && msk[wcnt_r];
    didx  = DIDX_W'(level_r[LEVEL_W-1:3]) + DIDX_W'(extra);
  end

  // sequencing and queue pop
  assign load_ok = !out_valid_r || out_ready;
  assign emit    = busy_r && load_ok;
  assign done    = emit && (wcnt_r == LAST_IDX);
  assign pop     = !q_stat.empty && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wcnt_r <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        wcnt_r <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
        wcnt_r <= '0;
      end else if (emit) begin
        wcnt_r <= wcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      level_r <= head_level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok) begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= density_word(didx);
      out_last_r <= (wcnt_r == LAST_IDX);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pdm_word  = out_word_r;
  assign out_last_word = out_last_r;

endmodule

>>> rtl/pcm_sample_to_pdm_block.sv
// ----------------------------------------------------------------------------
// pcm_sample_to_pdm_block
// PCM sample to pulse-density block encoder: eight 32-bit words per sample.
// ----------------------------------------------------------------------------
// the first word of a sample follows its level through the queue, the level
// register and the output register; one word per cycle leaves the back part
// unless out_ready stalls it; a 2-entry level queue lets the front accept
// while the back is expanding; reset: synchronous active-low rst_n, volume
// returns to 70, queue and output register empty
module pcm_sample_to_pdm_block (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pstp_pkg::SAMPLE_W-1:0] in_pcm_sample,
  input  logic                          in_silent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pstp_pkg::WORD_W-1:0]   out_pdm_word,
  output logic                          out_last_word,
  input  logic                          cfg_we,
  input  logic [pstp_pkg::VOL_W-1:0]    cfg_wdata
);
  import pstp_pkg::*;

  pstp_q_stat_t        q_stat;
  logic                push;
  logic [LEVEL_W-1:0]  push_level;
  logic                pop;
  logic [LEVEL_W-1:0]  head_level;

  // request intake and scaling
  pstp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pcm_sample (in_pcm_sample),
    .in_silent     (in_silent),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_stat        (q_stat),
    .push          (push),
    .push_level    (push_level)
  );

  // level queue
  pstp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_level (push_level),
    .pop        (pop),
    .head_level (head_level),
    .q_stat     (q_stat)
  );

  // word expansion
  pstp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_level    (head_level),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pdm_word  (out_pdm_word),
    .out_last_word (out_last_word)
  );

endmodule
